// ===== hw/rtl/rcng_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcng_pkg;

	// Width of one normalized color value and its full-scale code.
	localparam int NORM_W = 8;
	localparam logic [NORM_W-1:0] NORM_MAX = '1;

	// Red, green and blue travel side by side as three lanes.
	localparam int LANES = 3;
	localparam int LANE_RED = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE = 2;

	typedef logic [NORM_W-1:0] gamma_lut_t [2**NORM_W];

	// Gamma-2.5 curve with halves rounded up, in exact integer form.
	// Entry v is the count of k in 1..255 with (2k-1)^2 * 255^3 <= 4 * v^5;
	// the condition is monotone in k, so the count is the rounded value.
	function automatic gamma_lut_t build_gamma_lut();
		gamma_lut_t lut;
		longint unsigned cube;
		longint unsigned vv;
		longint unsigned lhs;
		longint unsigned odd;
		longint unsigned cnt;
		cube = 64'd255 * 64'd255 * 64'd255;
		for (int v = 0; v < 2**NORM_W; v++) begin
			vv = longint'(v);
			lhs = 64'd4 * vv * vv * vv * vv * vv;
			cnt = 64'd0;
			for (int k = 1; k < 2**NORM_W; k++) begin
				odd = 64'(2 * k - 1);
				if (odd * odd * cube <= lhs) begin
					cnt = cnt + 64'd1;
				end
			end
			lut[v] = cnt[NORM_W-1:0];
		end
		return lut;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_clear_normalize_gamma_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// -------   --------------------   --------------------------------------------------
// input     start / busy           raw_red, raw_green, raw_blue, raw_clear
// result    done (one-cycle word)  norm_red/green/blue, gamma_red/green/blue,
//                                  reading_valid, saturated
//
// One word enters per clock; busy is never raised because every stage moves on
// every clock. A result word appears on done after it has passed the stages in turn:
// one stage forms channel*255 and the saturation compare, four stages each
// resolve two quotient bits of the restoring divider, and one stage applies the
// clamp, the zero-clear rule and the gamma table. The receiver cannot stall, so
// no word is ever held back. The asynchronous reset clears only the valid bits;
// data registers are left as they are.

module rgb_clear_normalize_gamma_core
	import rcng_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [COUNT_BITS-1:0] raw_red,
	input  wire logic [COUNT_BITS-1:0] raw_green,
	input  wire logic [COUNT_BITS-1:0] raw_blue,
	input  wire logic [COUNT_BITS-1:0] raw_clear,
	output logic                       done,
	output logic [NORM_W-1:0]          norm_red,
	output logic [NORM_W-1:0]          norm_green,
	output logic [NORM_W-1:0]          norm_blue,
	output logic [NORM_W-1:0]          gamma_red,
	output logic [NORM_W-1:0]          gamma_green,
	output logic [NORM_W-1:0]          gamma_blue,
	output logic                       reading_valid,
	output logic                       saturated
);

	// Product channel*255 and the divider's partial remainder widths.
	localparam int NW = COUNT_BITS + NORM_W;
	localparam int RW = COUNT_BITS + 1;
	// Quotient bits are resolved two per stage.
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES = NORM_W / BITS_PER_STAGE;
	localparam int LATENCY = DIV_STAGES + 2;

	logic [COUNT_BITS-1:0] ch_in [LANES];

	// Stage 1: scaled numerator, initial remainder and per-lane saturation.
	logic                  valid_s1;
	logic                  zero_s1;
	logic [COUNT_BITS-1:0] clr_s1;
	logic [NORM_W-1:0]     num_s1 [LANES];
	logic [RW-1:0]         rem_s1 [LANES];
	logic                  sat_s1 [LANES];

	logic [NW-1:0]         prod_c [LANES];

	// Division stages s2 through s5, one array slot per stage.
	logic                  valid_sd [DIV_STAGES];
	logic                  zero_sd  [DIV_STAGES];
	logic [COUNT_BITS-1:0] clr_sd   [DIV_STAGES];
	logic [NORM_W-1:0]     num_sd   [DIV_STAGES][LANES];
	logic [RW-1:0]         rem_sd   [DIV_STAGES][LANES];
	logic [NORM_W-1:0]     quo_sd   [DIV_STAGES][LANES];
	logic                  sat_sd   [DIV_STAGES][LANES];

	logic [RW-1:0]         rem_nxt  [DIV_STAGES][LANES];
	logic [NORM_W-1:0]     quo_nxt  [DIV_STAGES][LANES];

	// Stage 6: the output word.
	logic                  valid_s6;
	logic [NORM_W-1:0]     norm_s6  [LANES];
	logic [NORM_W-1:0]     gamma_s6 [LANES];
	logic                  rvalid_s6;
	logic                  sat_s6;

	logic [NORM_W-1:0]     norm_nxt [LANES];
	logic                  sat_any;

	assign ch_in[LANE_RED]   = raw_red;
	assign ch_in[LANE_GREEN] = raw_green;
	assign ch_in[LANE_BLUE]  = raw_blue;

	// The pipeline never stops, so a new word is always welcome.
	assign busy = 1'b0;

	// channel*255 is a shift and a subtract. The quotient reaches 256 exactly
	// when the product is at least clear*256, which also catches a zero clear
	// count; that case is overridden at the end.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prod_c[l] = {ch_in[l], NORM_W'(0)} - NW'(ch_in[l]);
		end
	end

	// Restoring division, two bits per stage. When a lane is not saturated the
	// upper part of the product is already below the divisor, so only the low
	// eight product bits are shifted in.
	always_comb begin
		logic [RW-1:0]         r;
		logic [RW-1:0]         t;
		logic [NORM_W-1:0]     n;
		logic [NORM_W-1:0]     qq;
		logic [COUNT_BITS-1:0] d;
		int                    idx;
		for (int st = 0; st < DIV_STAGES; st++) begin
			for (int l = 0; l < LANES; l++) begin
				if (st == 0) begin
					r  = rem_s1[l];
					n  = num_s1[l];
					qq = '0;
					d  = clr_s1;
				end else begin
					r  = rem_sd[st-1][l];
					n  = num_sd[st-1][l];
					qq = quo_sd[st-1][l];
					d  = clr_sd[st-1];
				end
				for (int b = 0; b < BITS_PER_STAGE; b++) begin
					idx = NORM_W - 1 - st * BITS_PER_STAGE - b;
					t = {r[RW-2:0], n[idx]};
					if (t >= {1'b0, d}) begin
						r = t - {1'b0, d};
						qq[idx] = 1'b1;
					end else begin
						r = t;
					end
				end
				rem_nxt[st][l] = r;
				quo_nxt[st][l] = qq;
			end
		end
	end

	// Final selection: zero clear forces all zeros, a saturated lane reads full
	// scale, otherwise the quotient stands.
	always_comb begin
		sat_any = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			if (zero_sd[DIV_STAGES-1]) begin
				norm_nxt[l] = '0;
			end else if (sat_sd[DIV_STAGES-1][l]) begin
				norm_nxt[l] = NORM_MAX;
			end else begin
				norm_nxt[l] = quo_sd[DIV_STAGES-1][l];
			end
			sat_any = sat_any | sat_sd[DIV_STAGES-1][l];
		end
	end

	// Valid bits are the only state that reset clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int st = 0; st < DIV_STAGES; st++) begin
				valid_sd[st] <= 1'b0;
			end
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_sd[0] <= valid_s1;
			for (int st = 1; st < DIV_STAGES; st++) begin
				valid_sd[st] <= valid_sd[st-1];
			end
			valid_s6 <= valid_sd[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (raw_clear == '0);
		clr_s1  <= raw_clear;
		for (int l = 0; l < LANES; l++) begin
			num_s1[l] <= prod_c[l][NORM_W-1:0];
			rem_s1[l] <= {1'b0, prod_c[l][NW-1:NORM_W]};
			sat_s1[l] <= (prod_c[l] >= {raw_clear, NORM_W'(0)});
		end

		zero_sd[0] <= zero_s1;
		clr_sd[0]  <= clr_s1;
		for (int l = 0; l < LANES; l++) begin
			num_sd[0][l] <= num_s1[l];
			sat_sd[0][l] <= sat_s1[l];
		end
		for (int st = 1; st < DIV_STAGES; st++) begin
			zero_sd[st] <= zero_sd[st-1];
			clr_sd[st]  <= clr_sd[st-1];
			for (int l = 0; l < LANES; l++) begin
				num_sd[st][l] <= num_sd[st-1][l];
				sat_sd[st][l] <= sat_sd[st-1][l];
			end
		end
		for (int st = 0; st < DIV_STAGES; st++) begin
			for (int l = 0; l < LANES; l++) begin
				rem_sd[st][l] <= rem_nxt[st][l];
				quo_sd[st][l] <= quo_nxt[st][l];
			end
		end

		for (int l = 0; l < LANES; l++) begin
			norm_s6[l]  <= norm_nxt[l];
			gamma_s6[l] <= GAMMA_LUT[norm_nxt[l]];
		end
		rvalid_s6 <= ~zero_sd[DIV_STAGES-1];
		sat_s6    <= ~zero_sd[DIV_STAGES-1] & sat_any;
	end

	assign done          = valid_s6;
	assign norm_red      = norm_s6[LANE_RED];
	assign norm_green    = norm_s6[LANE_GREEN];
	assign norm_blue     = norm_s6[LANE_BLUE];
	assign gamma_red     = gamma_s6[LANE_RED];
	assign gamma_green   = gamma_s6[LANE_GREEN];
	assign gamma_blue    = gamma_s6[LANE_BLUE];
	assign reading_valid = rvalid_s6;
	assign saturated     = sat_s6;

	// Every accepted word comes out after the fixed pipeline depth.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result word missing at fixed latency");

	// A zero clear count gives an all-zero word.
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !reading_valid) |-> (norm_red == '0 && norm_green == '0 &&
		norm_blue == '0 && gamma_red == '0 && gamma_green == '0 &&
		gamma_blue == '0 && !saturated))
		else $error("invalid reading carries nonzero fields");

	// Saturation means at least one lane was clamped to full scale.
	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (norm_red == NORM_MAX || norm_green == NORM_MAX ||
		norm_blue == NORM_MAX))
		else $error("saturated flag without a clamped lane");

	// A gamma above one never lifts a value above its input.
	a_gamma_below: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (gamma_red <= norm_red && gamma_green <= norm_green &&
		gamma_blue <= norm_blue))
		else $error("gamma value exceeds normalized value");

endmodule

`default_nettype wire
